[rtl/core/asgd_pkg.sv]
// Package: shared constants and register codes for the shake gesture detector.
`timescale 1ns / 1ps
package asgd_pkg;

  localparam int unsigned SampleWidthDef = 16;
  localparam int unsigned CfgDataWidth   = 16;
  localparam int unsigned CfgIdxWidth    = 2;
  localparam int unsigned ThrWidth       = 16;
  localparam int unsigned NeedWidth      = 4;
  localparam int unsigned CountWidth     = 8;
  localparam int unsigned TimerWidth     = 16;

  localparam logic [ThrWidth-1:0]   ShakeThresholdRst = 16'd6400;
  localparam logic [ThrWidth-1:0]   StillBandRst      = 16'd256;
  localparam logic [NeedWidth-1:0]  ShakesNeededRst   = 4'd3;
  localparam logic [TimerWidth-1:0] TimeoutTicksRst   = 16'd450;

  localparam logic [CountWidth-1:0] CountMax = 8'd255;

  localparam logic OpSample = 1'b0;
  localparam logic OpTick   = 1'b1;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_SHAKE_THRESHOLD = 2'd0,
    CFG_STILL_BAND      = 2'd1,
    CFG_SHAKES_NEEDED   = 2'd2,
    CFG_TIMEOUT_TICKS   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                  detected;
    logic                  is_shaking;
    logic [CountWidth-1:0] shake_total;
  } result_t;

endpackage

[rtl/core/accel_shake_gesture_detector_top.sv]
// Shake gesture detector: per-axis delta check, shake counter and timeout.
// An accepted item's result goes to the output register, or to the skid if the output is stalled.
// Throughput: one item per cycle while the skid is empty (in_stall_o low); the whole update is one
// pass of subtract, compare and counter logic between the item and the state registers.
// A two-entry output (register plus skid) lets items flow while a result waits.
// Reset: asynchronous, active low; state clears to zero, registers to defaults.
`timescale 1ns / 1ps
module accel_shake_gesture_detector_top
  import asgd_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CfgIdxWidth-1:0]        cfg_idx_i,
  input  logic [CfgDataWidth-1:0]       cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          detected_o,
  output logic                          is_shaking_o,
  output logic [CountWidth-1:0]         shake_total_o
);

  localparam int unsigned CmpWidth = (SAMPLE_WIDTH > ThrWidth) ? SAMPLE_WIDTH : ThrWidth;

  // configuration
  logic [ThrWidth-1:0]   thr_q, band_q;
  logic [NeedWidth-1:0]  need_q;
  logic [TimerWidth-1:0] tmo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ShakeThresholdRst;
      band_q <= StillBandRst;
      need_q <= ShakesNeededRst;
      tmo_q  <= TimeoutTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_SHAKE_THRESHOLD: thr_q  <= cfg_data_i[ThrWidth-1:0];
        CFG_STILL_BAND:      band_q <= cfg_data_i[ThrWidth-1:0];
        CFG_SHAKES_NEEDED:   need_q <= cfg_data_i[NeedWidth-1:0];
        CFG_TIMEOUT_TICKS:   tmo_q  <= cfg_data_i[TimerWidth-1:0];
        default: ;
      endcase
    end
  end

  // state
  logic signed [SAMPLE_WIDTH-1:0] last_x_q, last_y_q, last_z_q;
  logic signed [SAMPLE_WIDTH-1:0] last_x_d, last_y_d, last_z_d;
  logic                  shaking_q, shaking_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [TimerWidth-1:0] left_q, left_d;
  logic                  running_q, running_d;
  logic                  det;

  // output register and skid
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d, skid_q, skid_d, res;

  logic in_acc, out_fire;
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  function automatic logic [SAMPLE_WIDTH-1:0] abs_diff(
    input logic signed [SAMPLE_WIDTH-1:0] a,
    input logic signed [SAMPLE_WIDTH-1:0] b
  );
    logic signed [SAMPLE_WIDTH:0] d;
    logic signed [SAMPLE_WIDTH:0] m;
    d = {a[SAMPLE_WIDTH-1], a} - {b[SAMPLE_WIDTH-1], b};
    m = d[SAMPLE_WIDTH] ? -d : d;
    return m[SAMPLE_WIDTH-1:0];
  endfunction

  logic [CmpWidth-1:0] dx, dy, dz, thr_w, band_w;
  logic                still, shake;
  logic [CountWidth-1:0] count_inc;

  always_comb begin
    dx     = CmpWidth'(abs_diff(last_x_q, accel_x_i));
    dy     = CmpWidth'(abs_diff(last_y_q, accel_y_i));
    dz     = CmpWidth'(abs_diff(last_z_q, accel_z_i));
    thr_w  = CmpWidth'(thr_q);
    band_w = CmpWidth'(band_q);
    still  = (dx < band_w) && (dy < band_w) && (dz < band_w);
    shake  = !still && ((dx > thr_w) || (dy > thr_w) || (dz > thr_w));
    count_inc = (count_q == CountMax) ? count_q : count_q + 1'b1;
  end

  always_comb begin
    last_x_d  = last_x_q;
    last_y_d  = last_y_q;
    last_z_d  = last_z_q;
    shaking_d = shaking_q;
    count_d   = count_q;
    left_d    = left_q;
    running_d = running_q;
    det       = 1'b0;
    if (op_i == OpSample) begin
      last_x_d = accel_x_i;
      last_y_d = accel_y_i;
      last_z_d = accel_z_i;
      if (shake && !shaking_q && (count_q >= CountWidth'(need_q))) begin
        shaking_d = 1'b1;
        count_d   = '0;
        det       = 1'b1;
      end else if (shake) begin
        count_d = count_inc;
        if (count_inc > CountWidth'(need_q)) begin
          left_d    = tmo_q;
          running_d = 1'b1;
        end
      end
    end else if (running_q) begin
      if (left_q <= TimerWidth'(1)) begin
        left_d    = '0;
        running_d = 1'b0;
        count_d   = '0;
        shaking_d = 1'b0;
      end else begin
        left_d = left_q - 1'b1;
      end
    end
    res.detected    = det;
    res.is_shaking  = shaking_d;
    res.shake_total = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q  <= '0;
      last_y_q  <= '0;
      last_z_q  <= '0;
      shaking_q <= 1'b0;
      count_q   <= '0;
      left_q    <= '0;
      running_q <= 1'b0;
    end else if (in_acc) begin
      last_x_q  <= last_x_d;
      last_y_q  <= last_y_d;
      last_z_q  <= last_z_d;
      shaking_q <= shaking_d;
      count_q   <= count_d;
      left_q    <= left_d;
      running_q <= running_d;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (in_acc) begin
      if (!out_valid_q || out_fire) begin
        out_valid_d = 1'b1;
        out_d       = res;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = res;
      end
    end else if (out_fire) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o   = out_valid_q;
  assign detected_o    = out_q.detected;
  assign is_shaking_o  = out_q.is_shaking;
  assign shake_total_o = out_q.shake_total;

endmodule

[dv/accel_shake_gesture_detector_top_tb.sv]
// Testbench for the shake gesture detector: directed and random items checked against a predictor.
`timescale 1ns / 1ps
module accel_shake_gesture_detector_top_tb;
  import asgd_pkg::*;

  localparam int unsigned HoldCycles = 300;
  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned MaxReports = 10;

  typedef logic signed [SampleWidthDef-1:0] sample_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx_i   = '0;
  logic [CfgDataWidth-1:0] cfg_data_i  = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic                    op_i        = OpSample;
  sample_t                 accel_x_i   = '0;
  sample_t                 accel_y_i   = '0;
  sample_t                 accel_z_i   = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    detected_o;
  logic                    is_shaking_o;
  logic [CountWidth-1:0]   shake_total_o;

  // predictor copy of registers and state
  logic [ThrWidth-1:0]   cfg_thr;
  logic [ThrWidth-1:0]   cfg_band;
  logic [NeedWidth-1:0]  cfg_need;
  logic [TimerWidth-1:0] cfg_timeout;
  sample_t               prev_x;
  sample_t               prev_y;
  sample_t               prev_z;
  logic                  shaking;
  logic [CountWidth-1:0] shake_count;
  logic [TimerWidth-1:0] ticks_left;
  logic                  timer_on;

  result_t     pending_results[$];
  result_t     got_r;
  result_t     want_r;
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_reqs    = 0;
  int unsigned holds_done   = 0;
  int unsigned tx_idle_pct  = 22;
  int unsigned rx_idle_pct  = 69;

  accel_shake_gesture_detector_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .accel_x_i     (accel_x_i),
    .accel_y_i     (accel_y_i),
    .accel_z_i     (accel_z_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .detected_o    (detected_o),
    .is_shaking_o  (is_shaking_o),
    .shake_total_o (shake_total_o)
  );

  initial forever #4 clk_i = ~clk_i;

  function automatic void reset_model();
    cfg_thr     = ShakeThresholdRst;
    cfg_band    = StillBandRst;
    cfg_need    = ShakesNeededRst;
    cfg_timeout = TimeoutTicksRst;
    prev_x      = '0;
    prev_y      = '0;
    prev_z      = '0;
    shaking     = 1'b0;
    shake_count = '0;
    ticks_left  = '0;
    timer_on    = 1'b0;
  endfunction

  function automatic int axis_delta(sample_t a, sample_t b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic result_t next_result(logic op, sample_t x, sample_t y, sample_t z);
    int      dx;
    int      dy;
    int      dz;
    logic    hit;
    result_t r;
    r = '0;
    if (op == OpSample) begin
      dx = axis_delta(x, prev_x);
      dy = axis_delta(y, prev_y);
      dz = axis_delta(z, prev_z);
      if (dx >= int'(cfg_band) || dy >= int'(cfg_band) || dz >= int'(cfg_band)) begin
        hit = (dx > int'(cfg_thr)) || (dy > int'(cfg_thr)) || (dz > int'(cfg_thr));
        if (hit && !shaking && shake_count >= cfg_need) begin
          shaking     = 1'b1;
          shake_count = '0;
          r.detected  = 1'b1;
        end else if (hit) begin
          if (shake_count != CountMax) shake_count++;
          if (shake_count > cfg_need) begin
            ticks_left = cfg_timeout;
            timer_on   = 1'b1;
          end
        end
      end
      prev_x = x;
      prev_y = y;
      prev_z = z;
    end else if (timer_on) begin
      if (ticks_left <= 1) begin
        ticks_left  = '0;
        timer_on    = 1'b0;
        shake_count = '0;
        shaking     = 1'b0;
      end else begin
        ticks_left--;
      end
    end
    r.is_shaking  = shaking;
    r.shake_total = shake_count;
    return r;
  endfunction

  function automatic sample_t rnd_sample();
    return sample_t'($urandom_range(16'hFFFF));
  endfunction

  function automatic int rnd_offset(int lo, int hi);
    int d;
    d = $urandom_range(hi, lo);
    return $urandom_range(1) ? d : -d;
  endfunction

  // move v by d, turning back or clamping at the rails
  function automatic sample_t nudge(sample_t v, int d);
    int t;
    t = int'(v) + d;
    if (t > 32767 || t < -32768) t = int'(v) - d;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return sample_t'(t);
  endfunction

  task automatic send_item(logic op, sample_t x, sample_t y, sample_t z);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    accel_x_i  <= x;
    accel_y_i  <= y;
    accel_z_i  <= z;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(next_result(op, x, y, z));
  endtask

  task automatic send_tick();
    send_item(OpTick, rnd_sample(), rnd_sample(), rnd_sample());
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataWidth-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_SHAKE_THRESHOLD: cfg_thr = val[ThrWidth-1:0];
      CFG_STILL_BAND:      cfg_band = val[ThrWidth-1:0];
      CFG_SHAKES_NEEDED:   cfg_need = val[NeedWidth-1:0];
      CFG_TIMEOUT_TICKS:   cfg_timeout = val[TimerWidth-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [CfgDataWidth-1:0] thr, logic [CfgDataWidth-1:0] band,
                            logic [CfgDataWidth-1:0] need, logic [CfgDataWidth-1:0] tmo);
    write_reg(CFG_SHAKE_THRESHOLD, thr);
    write_reg(CFG_STILL_BAND, band);
    write_reg(CFG_SHAKES_NEEDED, need);
    write_reg(CFG_TIMEOUT_TICKS, tmo);
  endtask

  task automatic random_item();
    int unsigned k;
    int          thr;
    int          band;
    k    = $urandom_range(99);
    thr  = int'(cfg_thr);
    band = int'(cfg_band);
    if (k < 35) begin
      send_tick();
    end else if (k < 60) begin
      send_item(OpSample, rnd_sample(), rnd_sample(), rnd_sample());
    end else if (k < 68) begin
      send_item(OpSample, nudge(prev_x, rnd_offset(thr + 1, thr + 3000)), prev_y, prev_z);
    end else if (k < 75) begin
      send_item(OpSample, prev_x, prev_y, nudge(prev_z, rnd_offset(thr + 1, thr + 3000)));
    end else if (k < 90) begin
      send_item(OpSample, prev_x, nudge(prev_y, rnd_offset(band, thr)), prev_z);
    end else begin
      send_item(OpSample, nudge(prev_x, rnd_offset(0, (band > 0) ? band - 1 : 0)),
                nudge(prev_y, rnd_offset(0, (band > 0) ? band - 1 : 0)),
                nudge(prev_z, rnd_offset(0, (band > 0) ? band - 1 : 0)));
    end
  endtask

  // reset settings: still samples, threshold edge, detection, timer start
  task automatic test_defaults();
    send_tick();
    send_item(OpSample, 16'sd0, 16'sd0, 16'sd0);
    send_item(OpSample, 16'sd255, -16'sd255, 16'sd0);
    send_item(OpSample, 16'sd511, -16'sd255, 16'sd0);
    send_item(OpSample, 16'sd32767, 16'sd0, 16'sd0);
    send_item(OpSample, -16'sd32768, -16'sd32768, -16'sd32768);
    send_item(OpSample, -16'sd32768, 16'sd32767, -16'sd32768);
    send_item(OpSample, -16'sd32768, 16'sd32767, 16'sd32767);
    send_item(OpSample, -16'sd32768, 16'sd32767, -16'sd32768);
    send_item(OpSample, -16'sd32768, 16'sd32767, 16'sd32767);
    send_item(OpSample, -16'sd32768, 16'sd32767, -16'sd32768);
    send_item(OpSample, -16'sd32768, 16'sd32767, 16'sd32767);
    send_tick();
    send_item(OpSample, -16'sd32668, 16'sd32767, 16'sd32767);
    send_item(OpSample, -16'sd26268, 16'sd32767, 16'sd32767);
    send_item(OpSample, -16'sd32669, 16'sd32767, 16'sd32767);
    send_tick();
  endtask

  task automatic test_config_extremes();
    settle();
    // zero threshold and band, need masked down to zero, zero timeout
    set_config(16'd0, 16'd0, 16'hFFF0, 16'd0);
    send_item(OpSample, prev_x, prev_y, prev_z);
    send_item(OpSample, nudge(prev_x, 1), prev_y, prev_z);
    send_item(OpSample, nudge(prev_x, 1), prev_y, prev_z);
    send_tick();
    send_item(OpSample, prev_x, nudge(prev_y, 1), prev_z);
    send_tick();
    settle();
    set_config(16'hFFFF, 16'hFFFF, 16'h000F, 16'hFFFF);
    send_item(OpSample, -16'sd32768, -16'sd32768, -16'sd32768);
    send_item(OpSample, 16'sd32767, 16'sd32767, 16'sd32767);
    send_item(OpSample, 16'sd0, 16'sd0, 16'sd0);
    send_tick();
  endtask

  task automatic test_counter_saturation();
    settle();
    set_config(16'd6400, 16'd256, 16'd15, 16'd5);
    for (int i = 0; i < 275; i++) begin
      send_item(OpSample, (i % 2 != 0) ? 16'sd20000 : -16'sd20000, rnd_sample(), rnd_sample());
    end
    repeat (4) send_tick();
    send_item(OpSample, nudge(prev_x, 30000), prev_y, prev_z);
    repeat (5) send_tick();
  endtask

  task automatic test_random(int unsigned tx, int unsigned rx, int unsigned blocks,
                             int unsigned per_block);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    repeat (blocks) begin
      settle();
      set_config(CfgDataWidth'(($urandom_range(4) != 0) ? $urandom_range(9000, 200)
                                                         : $urandom_range(65535)),
                 CfgDataWidth'(($urandom_range(4) != 0) ? $urandom_range(400)
                                                         : $urandom_range(65535)),
                 CfgDataWidth'($urandom_range(15)),
                 CfgDataWidth'(($urandom_range(4) != 0) ? $urandom_range(24, 1)
                                                         : $urandom_range(65535)));
      repeat (per_block) random_item();
    end
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    settle();
    hold_reqs++;
    repeat (40) random_item();
    settle();
  endtask

  initial begin
    reset_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_config_extremes();
    test_counter_saturation();
    test_random(22, 69, 3, 100);
    test_random(69, 22, 3, 100);
    test_backpressure();
    test_random(0, 0, 3, 100);
    settle();
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("accel_shake_gesture_detector_top_tb: clean");
    end else begin
      $display("accel_shake_gesture_detector_top_tb: errors");
    end
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_r = {detected_o, is_shaking_o, shake_total_o};
      if (pending_results.size() == 0) begin
        if (fail_count < MaxReports) begin
          $display("%0t: result with none outstanding: det=%0b shk=%0b tot=%0d",
                   $time, got_r.detected, got_r.is_shaking, got_r.shake_total);
        end
        fail_count++;
      end else begin
        want_r = pending_results.pop_front();
        if (got_r.detected !== want_r.detected || got_r.is_shaking !== want_r.is_shaking ||
            got_r.shake_total !== want_r.shake_total) begin
          if (fail_count < MaxReports) begin
            $display("%0t: mismatch: want det=%0b shk=%0b tot=%0d, got det=%0b shk=%0b tot=%0d",
                     $time, want_r.detected, want_r.is_shaking, want_r.shake_total,
                     got_r.detected, got_r.is_shaking, got_r.shake_total);
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("accel_shake_gesture_detector_top_tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
